// ----- hw/rtl/lapc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapc_pkg
// Shared types and constants of the linear actuator position commander.
// ----------------------------------------------------------------------------
package lapc_pkg;

    localparam int FEEDBACK_BITS = 10;
    localparam int S_TDATA_W     = ((FEEDBACK_BITS + 16 + 7) / 8) * 8;
    localparam int PADDR_W       = 5;

    // raw window compare width, wide enough for the upper window edge
    localparam int RAW_EXT_W = (FEEDBACK_BITS > 9) ? FEEDBACK_BITS : 9;
    localparam logic [RAW_EXT_W-1:0] RAW_LOW  = RAW_EXT_W'(46);
    localparam logic [RAW_EXT_W-1:0] RAW_HIGH = RAW_EXT_W'(318);
    localparam logic [8:0]           RAW_SPAN = 9'd272;

    // (d * 20540) / 272 == (d * MAP_MULT) >> MAP_SHIFT for d in 0..272
    localparam logic [21:0] MAP_MULT  = 22'd2474466;
    localparam int          MAP_SHIFT = 15;
    localparam logic [15:0] DIST_LOW  = 16'd2260;
    localparam logic [15:0] DIST_HIGH = 16'd22800;
    localparam logic [8:0]  ALPHA_ONE = 9'd256;

    localparam int MUL_A_W = 9;
    localparam int MUL_B_W = 22;

    localparam logic [1:0] KIND_REPORT = 2'd0;
    localparam logic [1:0] KIND_MOVE   = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [2:0] REG_DEFAULT_LIFT    = 3'd0;
    localparam logic [2:0] REG_MIN_LIFT        = 3'd1;
    localparam logic [2:0] REG_MAX_LIFT        = 3'd2;
    localparam logic [2:0] REG_SETPOINT_OFFSET = 3'd3;
    localparam logic [2:0] REG_FILTER_ALPHA    = 3'd4;
    localparam logic [2:0] REG_STOP_CENTER     = 3'd5;
    localparam logic [2:0] REG_STOP_HALFWIDTH  = 3'd6;

    typedef struct packed {
        logic [15:0] default_lift;
        logic [15:0] min_lift;
        logic [15:0] max_lift;
        logic [12:0] setpoint_offset;
        logic [8:0]  filter_alpha;
        logic [14:0] stop_center;
        logic [13:0] stop_halfwidth;
    } t_cfg;

    typedef enum logic [2:0] {
        ALU_NONE = 3'd0,
        ALU_MUL  = 3'd1,
        ALU_MAC  = 3'd2,
        ALU_ADD  = 3'd3,
        ALU_SUB  = 3'd4
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

endpackage

// ----- hw/rtl/lapc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapc_regs
// APB configuration registers of the position commander.
// ----------------------------------------------------------------------------
module lapc_regs
    import lapc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.default_lift    <= 16'd0;
            r_cfg.min_lift        <= 16'd0;
            r_cfg.max_lift        <= 16'd0;
            r_cfg.setpoint_offset <= 13'd1400;
            r_cfg.filter_alpha    <= 9'd128;
            r_cfg.stop_center     <= 15'd1300;
            r_cfg.stop_halfwidth  <= 14'd300;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEFAULT_LIFT:    r_cfg.default_lift    <= pwdata[15:0];
                REG_MIN_LIFT:        r_cfg.min_lift        <= pwdata[15:0];
                REG_MAX_LIFT:        r_cfg.max_lift        <= pwdata[15:0];
                REG_SETPOINT_OFFSET: r_cfg.setpoint_offset <= pwdata[12:0];
                REG_FILTER_ALPHA:    r_cfg.filter_alpha    <= pwdata[8:0];
                REG_STOP_CENTER:     r_cfg.stop_center     <= pwdata[14:0];
                REG_STOP_HALFWIDTH:  r_cfg.stop_halfwidth  <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEFAULT_LIFT:    prdata = 32'(r_cfg.default_lift);
            REG_MIN_LIFT:        prdata = 32'(r_cfg.min_lift);
            REG_MAX_LIFT:        prdata = 32'(r_cfg.max_lift);
            REG_SETPOINT_OFFSET: prdata = 32'(r_cfg.setpoint_offset);
            REG_FILTER_ALPHA:    prdata = 32'(r_cfg.filter_alpha);
            REG_STOP_CENTER:     prdata = 32'(r_cfg.stop_center);
            REG_STOP_HALFWIDTH:  prdata = 32'(r_cfg.stop_halfwidth);
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ----- hw/rtl/lapc_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapc_alu
// Shared multiply-accumulate and add/subtract unit with a registered result.
// ----------------------------------------------------------------------------
module lapc_alu
    import lapc_pkg::*;
(
    input  logic        i_clk,
    input  t_alu_req    i_req,
    output logic [31:0] o_acc
);

    logic [31:0]                r_acc;
    logic [MUL_A_W+MUL_B_W-1:0] prod;

    assign prod  = i_req.a[MUL_A_W-1:0] * i_req.b[MUL_B_W-1:0];
    assign o_acc = r_acc;

    always_ff @(posedge i_clk) begin
        unique case (i_req.op)
            ALU_NONE: r_acc <= r_acc;
            ALU_MUL:  r_acc <= 32'(prod);
            ALU_MAC:  r_acc <= r_acc + 32'(prod);
            ALU_ADD:  r_acc <= i_req.a + i_req.b;
            ALU_SUB:  r_acc <= i_req.a - i_req.b;
            default:  r_acc <= r_acc;
        endcase
    end

endmodule

// ----- hw/rtl/lapc_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapc_seq
// Sequencer: steps the shared unit through the feedback map and filter or the
// setpoint clamp and stop window test, holds the state and the result beat.
// ----------------------------------------------------------------------------
module lapc_seq
    import lapc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_opcode,
    input  logic [FEEDBACK_BITS-1:0] i_raw,
    input  logic [15:0]              i_cmd,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_out_kind,
    output logic [15:0]              o_out_value,
    output t_alu_req                 o_alu_req,
    input  logic [31:0]              i_acc
);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_F_MUL  = 14'b00000000000010,
        ST_F_ADD  = 14'b00000000000100,
        ST_F_PREV = 14'b00000000001000,
        ST_F_NEW  = 14'b00000000010000,
        ST_F_DONE = 14'b00000000100000,
        ST_W_LO   = 14'b00000001000000,
        ST_W_HI   = 14'b00000010000000,
        ST_W_CHK  = 14'b00000100000000,
        ST_W_OFS  = 14'b00001000000000,
        ST_W_ERR  = 14'b00010000000000,
        ST_W_DEV  = 14'b00100000000000,
        ST_W_GT   = 14'b01000000000000,
        ST_W_LT   = 14'b10000000000000
    } t_state;

    t_state n_state;
    t_state r_state;

    logic        r_w_done;
    logic [8:0]  r_d;
    logic [15:0] r_cmd;
    logic [15:0] r_now;
    logic [15:0] r_sp;
    logic [19:0] r_dev;
    logic        r_gt;
    logic [15:0] r_last;
    logic [15:0] r_filt;
    logic [15:0] r_prev_sp;
    logic        r_stop;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [15:0] r_out_value;

    logic [RAW_EXT_W-1:0] raw_ext;
    logic [RAW_EXT_W-1:0] raw_off;
    logic [8:0]           d_clamped;
    logic [8:0]           alpha_sat;
    logic [8:0]           alpha_rest;
    logic [15:0]          sp_sat;
    logic                 out_free;
    logic                 move;
    logic                 stop_emit;
    logic                 emit;
    logic                 w_finish;
    logic                 out_load;

    // write items end in ST_W_LT with a second pass flagged by r_w_done
    assign raw_ext    = RAW_EXT_W'(i_raw);
    assign raw_off    = raw_ext - RAW_LOW;
    assign alpha_sat  = (i_cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.filter_alpha;
    assign alpha_rest = ALPHA_ONE - alpha_sat;
    assign sp_sat     = i_acc[16] ? 16'hFFFF : i_acc[15:0];
    assign out_free   = !r_out_valid || i_out_ready;
    assign move       = (r_sp != r_prev_sp);
    assign stop_emit  = !move && r_gt && i_acc[31] && !r_stop;
    assign emit       = move || stop_emit;
    assign w_finish   = r_w_done && (!emit || out_free);
    assign out_load   = ((r_state == ST_F_DONE) && out_free) ||
                        ((r_state == ST_W_LT) && w_finish && emit);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;

    always_comb begin
        if (raw_ext < RAW_LOW) begin
            d_clamped = 9'd0;
        end else if (raw_ext > RAW_HIGH) begin
            d_clamped = RAW_SPAN;
        end else begin
            d_clamped = raw_off[8:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        o_alu_req.op = ALU_NONE;
        o_alu_req.a  = 32'd0;
        o_alu_req.b  = 32'd0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_opcode ? ST_W_LO : ST_F_MUL;
                end
            end
            ST_F_MUL: begin
                o_alu_req.op = ALU_MUL;
                o_alu_req.a  = 32'(r_d);
                o_alu_req.b  = 32'(MAP_MULT);
                n_state      = ST_F_ADD;
            end
            ST_F_ADD: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = i_acc >> MAP_SHIFT;
                o_alu_req.b  = 32'(DIST_LOW);
                n_state      = ST_F_PREV;
            end
            ST_F_PREV: begin
                o_alu_req.op = ALU_MUL;
                o_alu_req.a  = 32'(alpha_sat);
                o_alu_req.b  = 32'(r_last);
                n_state      = ST_F_NEW;
            end
            ST_F_NEW: begin
                o_alu_req.op = ALU_MAC;
                o_alu_req.a  = 32'(alpha_rest);
                o_alu_req.b  = 32'(r_now);
                n_state      = ST_F_DONE;
            end
            ST_F_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_W_LO: begin
                o_alu_req.op = ALU_SUB;
                o_alu_req.a  = 32'(r_cmd);
                o_alu_req.b  = 32'(i_cfg.min_lift);
                n_state      = ST_W_HI;
            end
            ST_W_HI: begin
                if (i_acc[31]) begin
                    n_state = ST_W_OFS;
                end else begin
                    o_alu_req.op = ALU_SUB;
                    o_alu_req.a  = 32'(i_cfg.max_lift);
                    o_alu_req.b  = 32'(r_cmd);
                    n_state      = ST_W_CHK;
                end
            end
            ST_W_CHK: begin
                n_state = ST_W_OFS;
            end
            ST_W_OFS: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = 32'(r_cmd);
                o_alu_req.b  = 32'(i_cfg.setpoint_offset);
                n_state      = ST_W_ERR;
            end
            ST_W_ERR: begin
                o_alu_req.op = ALU_SUB;
                o_alu_req.a  = 32'(sp_sat);
                o_alu_req.b  = 32'(r_filt);
                n_state      = ST_W_DEV;
            end
            ST_W_DEV: begin
                o_alu_req.op = ALU_SUB;
                o_alu_req.a  = i_acc;
                o_alu_req.b  = {{17{i_cfg.stop_center[14]}}, i_cfg.stop_center};
                n_state      = ST_W_GT;
            end
            ST_W_GT: begin
                o_alu_req.op = ALU_ADD;
                o_alu_req.a  = i_acc;
                o_alu_req.b  = 32'(i_cfg.stop_halfwidth);
                n_state      = ST_W_LT;
            end
            ST_W_LT: begin
                if (!r_w_done) begin
                    o_alu_req.op = ALU_SUB;
                    o_alu_req.a  = {{12{r_dev[19]}}, r_dev};
                    o_alu_req.b  = 32'(i_cfg.stop_halfwidth);
                end else if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_w_done    <= 1'b0;
            r_last      <= 16'd0;
            r_filt      <= 16'd0;
            r_prev_sp   <= 16'd0;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_w_done <= 1'b0;
                    if (i_in_valid) begin
                        r_d   <= d_clamped;
                        r_cmd <= (i_cmd == 16'd0) ? i_cfg.default_lift : i_cmd;
                    end
                end
                ST_F_PREV: begin
                    r_now <= i_acc[15:0];
                end
                ST_F_DONE: begin
                    if (out_free) begin
                        r_filt      <= i_acc[23:8];
                        r_last      <= r_now;
                        r_out_kind  <= KIND_REPORT;
                        r_out_value <= r_now;
                    end
                end
                ST_W_HI: begin
                    if (i_acc[31]) begin
                        r_cmd <= i_cfg.min_lift;
                    end
                end
                ST_W_CHK: begin
                    if (i_acc[31]) begin
                        r_cmd <= i_cfg.max_lift;
                    end
                end
                ST_W_ERR: begin
                    r_sp <= sp_sat;
                end
                ST_W_GT: begin
                    r_dev <= i_acc[19:0];
                end
                ST_W_LT: begin
                    if (!r_w_done) begin
                        r_gt     <= !i_acc[31] && (i_acc != 32'd0);
                        r_w_done <= 1'b1;
                    end else if (w_finish) begin
                        r_prev_sp <= r_sp;
                        if (move) begin
                            r_stop      <= 1'b0;
                            r_out_kind  <= KIND_MOVE;
                            r_out_value <= r_sp;
                        end else if (stop_emit) begin
                            r_stop      <= 1'b1;
                            r_out_kind  <= KIND_STOP;
                            r_out_value <= 16'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/linear_actuator_position_commander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_actuator_position_commander
// Maps potentiometer feedback to a filtered position and turns lift commands
// into move and stop beats.
// ----------------------------------------------------------------------------
// One input beat is worked at a time by a single shared multiply-accumulate
// and add/subtract unit under a small sequencer; s_axis_tready is high only
// while the sequencer is idle. A feedback beat (tuser 0) runs two multiplies,
// one add and one accumulate between its accept and the next accept; a write
// beat (tuser 1) runs the clamp compares, the offset add and the stop window
// subtractions, skipping the max_lift compare when below min_lift. A
// finished result sits in an output register, so the next beat is accepted
// while it waits; the sequencer only holds at its last step when a new
// result finds that register still full. Configuration registers sit on the
// APB port at byte addresses 4*i and should be written while idle.
// ----------------------------------------------------------------------------
module linear_actuator_position_commander
    import lapc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // raw reading, commanded position
    input  logic                 i_s_axis_tuser,  // opcode
    // master side
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,  // value
    output logic [1:0]           o_m_axis_tuser,  // kind
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_cfg        cfg;
    t_alu_req    alu_req;
    logic [31:0] acc;

    lapc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lapc_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_acc (acc)
    );

    lapc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_raw       (i_s_axis_tdata[FEEDBACK_BITS-1:0]),
        .i_cmd       (i_s_axis_tdata[FEEDBACK_BITS+15:FEEDBACK_BITS]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_kind  (o_m_axis_tuser),
        .o_out_value (o_m_axis_tdata),
        .o_alu_req   (alu_req),
        .i_acc       (acc)
    );

    // one beat in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_STOP)) |-> (o_m_axis_tdata == 16'd0))
        else $error("stop beat with nonzero value");

    a_report_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_REPORT)) |->
        ((o_m_axis_tdata >= DIST_LOW) && (o_m_axis_tdata <= DIST_HIGH)))
        else $error("report position outside mapped range");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tuser == KIND_REPORT) ||
        (o_m_axis_tuser == KIND_MOVE) || (o_m_axis_tuser == KIND_STOP)))
        else $error("illegal result kind");

endmodule

// ----- tb/sv/tb_linear_actuator_position_commander.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_actuator_position_commander
// Drives feedback and write beats into the actuator commander, predicts every
// position report, move and stop beat, and compares them in order. Runs a
// short directed set, then random phases under changing register settings,
// with bursty input, a stalling output side and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_linear_actuator_position_commander;
    import lapc_pkg::*;

    localparam logic OP_FEEDBACK  = 1'b0;
    localparam logic OP_WRITE     = 1'b1;
    localparam int   RAW_MIN      = 46;
    localparam int   RAW_MAX      = 318;
    localparam int   POS_MIN      = 2260;
    localparam int   POS_MAX      = 22800;
    localparam int   CYCLE_LIMIT  = 1_000_000;
    localparam int   DRAIN_CYCLES = 24;
    localparam int   PHASE_BEATS  = 200;
    localparam int   RAND_PHASES  = 8;

    typedef struct packed {
        logic                     op;
        logic [FEEDBACK_BITS-1:0] raw;
        logic [15:0]              cmd;
    } t_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
    } t_result;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    wire                  s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    wire                  m_tvalid;
    logic                 m_tready = 1'b0;
    wire  [15:0]          m_tdata;
    wire  [1:0]           m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [31:0]          pwdata   = '0;
    wire  [31:0]          prdata;
    wire                  pready;

    linear_actuator_position_commander DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // commander shadow: registers and state
    t_cfg        cmd_cfg;
    logic [15:0] pos_last    = '0;
    logic [15:0] pos_filt    = '0;
    logic [15:0] sp_prev     = '0;
    logic        stop_sent   = 1'b0;

    t_beat       beat_q[$];
    t_result     result_q[$];
    t_beat       beat_on_bus;
    int          err_count   = 0;
    int          beats_taken = 0;
    int          cycle_count = 0;

    function automatic int pos_from_raw(input logic [FEEDBACK_BITS-1:0] raw);
        int r;
        r = raw;
        if (r < RAW_MIN) r = RAW_MIN;
        if (r > RAW_MAX) r = RAW_MAX;
        return POS_MIN + ((r - RAW_MIN) * (POS_MAX - POS_MIN)) / (RAW_MAX - RAW_MIN);
    endfunction

    function automatic void cfg_shadow_write(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_DEFAULT_LIFT:    cmd_cfg.default_lift    = val[15:0];
            REG_MIN_LIFT:        cmd_cfg.min_lift        = val[15:0];
            REG_MAX_LIFT:        cmd_cfg.max_lift        = val[15:0];
            REG_SETPOINT_OFFSET: cmd_cfg.setpoint_offset = val[12:0];
            REG_FILTER_ALPHA:    cmd_cfg.filter_alpha    = val[8:0];
            REG_STOP_CENTER:     cmd_cfg.stop_center     = val[14:0];
            REG_STOP_HALFWIDTH:  cmd_cfg.stop_halfwidth  = val[13:0];
            default: ;
        endcase
    endfunction

    function automatic void queue_result(input logic [1:0] kind, input logic [15:0] value);
        t_result res;
        res.kind  = kind;
        res.value = value;
        result_q.insert(result_q.size(), res);
    endfunction

    function automatic void predict_commander(input t_beat b);
        int alpha, now, cmd, sp, err, ctr, tol;
        if (b.op == OP_FEEDBACK) begin
            alpha = int'(cmd_cfg.filter_alpha);
            if (alpha > 256) alpha = 256;
            now = pos_from_raw(b.raw);
            pos_filt = 16'((alpha * int'(pos_last) + (256 - alpha) * now) >> 8);
            pos_last = 16'(now);
            queue_result(KIND_REPORT, 16'(now));
        end else begin
            cmd = int'(b.cmd);
            if (cmd == 0) cmd = int'(cmd_cfg.default_lift);
            if (cmd < int'(cmd_cfg.min_lift)) cmd = int'(cmd_cfg.min_lift);
            else if (cmd > int'(cmd_cfg.max_lift)) cmd = int'(cmd_cfg.max_lift);
            sp = cmd + int'(cmd_cfg.setpoint_offset);
            if (sp > 65535) sp = 65535;
            err = sp - int'(pos_filt);
            ctr = int'($signed(cmd_cfg.stop_center));
            tol = int'(cmd_cfg.stop_halfwidth);
            if (sp != int'(sp_prev)) begin
                queue_result(KIND_MOVE, 16'(sp));
                stop_sent = 1'b0;
            end else if (err > ctr - tol && err < ctr + tol && !stop_sent) begin
                queue_result(KIND_STOP, 16'd0);
                stop_sent = 1'b1;
            end
            sp_prev = 16'(sp);
        end
    endfunction

    // input side: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic  offering;
        t_beat nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                predict_commander(beat_on_bus);
                beats_taken++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    nxt = beat_q.pop_front();
                    beat_on_bus = nxt;
                    s_tdata  <= S_TDATA_W'({nxt.cmd, nxt.raw});
                    s_tuser  <= nxt.op;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: stall pattern, with one forced long hold-off
    t_rx_mode rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    bit       long_done = 1'b0;

    always @(posedge i_clk) begin
        logic rdy;
        int   pick;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (!long_done && beats_taken > 400 && beat_q.size() > 30) begin
                long_done = 1'b1;
                rx_mode   = RX_HOLD;
                rx_left   = 600;
            end else if (rx_left == 0) begin
                pick = $urandom_range(0, 15);
                if (pick < 5) rx_mode = RX_OPEN;
                else if (pick < 10) rx_mode = RX_COIN;
                else if (pick < 15) rx_mode = RX_SPARSE;
                else rx_mode = RX_HOLD;
                rx_left = (rx_mode == RX_HOLD) ? $urandom_range(100, 300)
                                               : $urandom_range(5, 60);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   rdy = 1'b1;
                RX_COIN:   rdy = 1'($urandom_range(0, 1));
                RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                default:   rdy = 1'b0;
            endcase
            m_tready <= rdy;
        end
    end

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        err_count++;
        if (err_count <= 10)
            $display("mismatch (%s): expected kind %0d value %0d, got kind %0d value %0d",
                     what, want.kind, want.value, got.kind, got.value);
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{kind: m_tuser, value: m_tdata};
            if (result_q.size() == 0) begin
                note_mismatch("no beat expected", '0, got);
            end else begin
                want = result_q.pop_front();
                if (got.kind !== want.kind || got.value !== want.value)
                    note_mismatch("field", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_linear_actuator_position_commander: done, errors");
            $finish;
        end
    end

    function automatic void push_fb(input int raw);
        t_beat b;
        b.op  = OP_FEEDBACK;
        b.raw = FEEDBACK_BITS'(raw);
        b.cmd = 16'($urandom);
        beat_q.insert(beat_q.size(), b);
    endfunction

    function automatic void push_wr(input int cmd);
        t_beat b;
        b.op  = OP_WRITE;
        b.raw = FEEDBACK_BITS'($urandom);
        b.cmd = 16'(cmd);
        beat_q.insert(beat_q.size(), b);
    endfunction

    function automatic int pick_range(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow_write(idx, val);
    endtask

    task automatic load_cfg(input int dl, input int ml, input int xl, input int off,
                            input int alpha, input int ctr, input int tol);
        reg_write(REG_DEFAULT_LIFT,    32'(dl & 16'hFFFF));
        reg_write(REG_MIN_LIFT,        32'(ml & 16'hFFFF));
        reg_write(REG_MAX_LIFT,        32'(xl & 16'hFFFF));
        reg_write(REG_SETPOINT_OFFSET, 32'(off & 13'h1FFF));
        reg_write(REG_FILTER_ALPHA,    32'(alpha & 9'h1FF));
        reg_write(REG_STOP_CENTER,     32'(ctr & 15'h7FFF));
        reg_write(REG_STOP_HALFWIDTH,  32'(tol & 14'h3FFF));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (beat_q.size() > 0 || s_tvalid || result_q.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_random_phase(input int n);
        int added, sel, raw, tgt, reps, ctr, tol, cmd;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                // settle the filter on one reading, then command near the stop window
                raw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(RAW_MIN, RAW_MAX);
                ctr = int'($signed(cmd_cfg.stop_center));
                tol = int'(cmd_cfg.stop_halfwidth);
                tgt = pos_from_raw(FEEDBACK_BITS'(raw)) + ctr
                      - int'(cmd_cfg.setpoint_offset) + int'($urandom_range(0, 2 * tol)) - tol;
                if (tgt < 1) tgt = 1;
                if (tgt > 65535) tgt = 65535;
                push_fb(raw);
                push_fb(raw);
                reps = $urandom_range(2, 4);
                repeat (reps) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_fb(raw);
                        added++;
                    end
                    push_wr(tgt);
                end
                added += 2 + reps;
            end else if (sel < 70) begin
                cmd  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 65535);
                reps = $urandom_range(2, 3);
                repeat (reps) push_wr(cmd);
                added += reps;
            end else begin
                if ($urandom_range(0, 1) == 0) push_fb($urandom_range(0, 1023));
                else push_wr(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535));
                added++;
            end
        end
    endtask

    initial begin
        int ml;
        cmd_cfg = '{default_lift: 16'd0, min_lift: 16'd0, max_lift: 16'd0,
                    setpoint_offset: 13'd1400, filter_alpha: 9'd128,
                    stop_center: 15'd1300, stop_halfwidth: 14'd300};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: raw window edges and the default lift
        push_fb(0);
        push_fb(45);
        push_fb(46);
        push_fb(47);
        push_fb(318);
        push_fb(319);
        push_fb(1023);
        push_fb(682);
        push_fb(341);
        push_wr(0);
        push_wr(65535);
        wait_drained();

        // move, hold, stop once, clamps at both limits
        load_cfg(20000, 1000, 40000, 1400, 128, 1300, 300);
        push_fb(200);
        push_fb(200);
        push_wr(0);
        push_wr(0);
        push_wr(13800);
        push_wr(13800);
        push_wr(13800);
        push_wr(500);
        push_wr(65535);
        wait_drained();

        // inverted limits, alpha above one, most negative window
        load_cfg(65535, 50000, 30000, 8191, 511, 16384, 16383);
        push_wr(40000);
        push_wr(60000);
        push_wr(0);
        push_fb(1023);
        push_fb(0);
        wait_drained();

        // setpoint saturation with an empty stop window
        load_cfg(0, 0, 65535, 8191, 0, 16383, 0);
        push_wr(65535);
        push_wr(60000);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                load_cfg(0, 0, 65535, 0, 256, 0, 16383);
            end else begin
                ml = ($urandom_range(0, 4) == 0) ? pick_range(0, 65535) : pick_range(0, 30000);
                load_cfg(pick_range(0, 65535), ml,
                         ($urandom_range(0, 4) == 0) ? pick_range(0, 65535)
                                                     : pick_range(ml, 65535),
                         pick_range(0, 8191),
                         ($urandom_range(0, 3) == 0) ? pick_range(0, 511)
                                                     : pick_range(0, 256),
                         ($urandom_range(0, 1) == 0) ? pick_range(0, 4000) - 2000
                                                     : pick_range(0, 32767) - 16384,
                         ($urandom_range(0, 3) == 0) ? pick_range(0, 16383)
                                                     : pick_range(0, 3000));
            end
            fill_random_phase(PHASE_BEATS);
            wait_drained();
        end

        if (err_count == 0) begin
            $display("tb_linear_actuator_position_commander: done, clean");
        end else begin
            $display("tb_linear_actuator_position_commander: done, errors");
        end
        $finish;
    end

endmodule
